/* hdl/lol_pkg.sv */
package lol_pkg;

  localparam int ROW_WIDTH_W = 11;
  localparam int RUN_OUT_W   = 11;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 11'd1024;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  localparam logic [1:0] OUT_DEPTH = 2'd2;

  typedef struct packed {
    logic valid;
    logic px;
    logic eof;
    logic first_col;
    logic last_col;
    logic first_row;
  } lol_stage_t;

endpackage

/* hdl/lol_ram.sv */
module lol_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/lol_out_fifo.sv */
module lol_out_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [lol_pkg::RUN_OUT_W-1:0]  push_data,
  input  logic                           pop,
  output logic                           valid,
  output logic [lol_pkg::RUN_OUT_W-1:0]  data,
  output logic [1:0]                     count
);

  import lol_pkg::*;

  logic [RUN_OUT_W-1:0] slot [2];
  logic                 rd_ptr;
  logic                 wr_ptr;
  logic                 do_pop;

  assign valid  = (count != 2'd0);
  assign data   = slot[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && (count != OUT_DEPTH)) begin
        slot[wr_ptr] <= push_data;
        wr_ptr       <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push && (count != OUT_DEPTH), do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/longest_line_of_ones.sv */
// the end of a frame is registered in the s1 stage, and its result then in the result queue
// throughput: one pixel per clock unless stalled; one line buffer read and write per pixel
// a two-entry result queue lets pixels keep flowing while a result waits on the output
// reset (rst, synchronous, active high): row width 1024, top row, runs and maximum cleared
// line buffer contents are not cleared; no clearing pass after reset
module longest_line_of_ones #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [lol_pkg::ROW_WIDTH_W-1:0]   cfg_wr_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [lol_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [0] pixel
  input  logic                              s_axis_tlast,  // end_of_frame
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [lol_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // [10:0] longest_run
);

  import lol_pkg::*;

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNT_W = $clog2(MAX_COLS + 1);
  localparam int RUN_W = $clog2(MAX_ROWS + 1);
  localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(MAX_ROWS);

  function automatic logic [RUN_W-1:0] grow(input logic [RUN_W-1:0] prior);
    return (prior >= RUN_MAX) ? RUN_MAX : prior + RUN_W'(1);
  endfunction

  function automatic logic [RUN_W-1:0] wider(input logic [RUN_W-1:0] a,
                                             input logic [RUN_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic [ROW_WIDTH_W-1:0] row_width;
  logic [CNT_W-1:0]       width_eff;
  logic [COL_W-1:0]       col;
  logic [COL_W-1:0]       anti_raddr;
  logic                   first_row;
  logic                   last_col;
  logic                   in_acc;

  lol_stage_t             s1;
  logic [COL_W-1:0]       s1_col;

  logic [RUN_W-1:0]       horizontal_run;
  logic [RUN_W-1:0]       upper_left_hold;
  logic [RUN_W-1:0]       longest_so_far;

  logic [2*RUN_W-1:0]     vd_rdata;
  logic [RUN_W-1:0]       anti_rdata;

  logic                   fwd_vd;
  logic                   fwd_a;
  logic [RUN_W-1:0]       fwd_v_val;
  logic [RUN_W-1:0]       fwd_d_val;
  logic [RUN_W-1:0]       fwd_a_val;

  logic [RUN_W-1:0]       up;
  logic [RUN_W-1:0]       old_diag;
  logic [RUN_W-1:0]       up_right;
  logic [RUN_W-1:0]       up_left;
  logic [RUN_W-1:0]       h_run;
  logic [RUN_W-1:0]       v_run;
  logic [RUN_W-1:0]       d_run;
  logic [RUN_W-1:0]       a_run;
  logic [RUN_W-1:0]       longest_next;

  logic                   res_push;
  logic [1:0]             res_count;
  logic [RUN_OUT_W-1:0]   res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RESET;
    end else if (cfg_wr_en) begin
      row_width <= cfg_wr_data;
    end
  end

  always_comb begin
    priority if (32'(row_width) > MAX_COLS) begin
      width_eff = CNT_W'(MAX_COLS);
    end else if (row_width == '0) begin
      width_eff = CNT_W'(1);
    end else begin
      width_eff = CNT_W'(row_width);
    end
  end

  assign last_col      = (CNT_W'(col) + CNT_W'(1)) >= width_eff;
  assign anti_raddr    = COL_W'(CNT_W'(col) + CNT_W'(1));
  assign s_axis_tready = !rst &&
                         ((res_count == 2'd0) ||
                          ((res_count == 2'd1) && !(s1.valid && s1.eof)));
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // front: column tracking and line buffer reads
  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      first_row <= 1'b1;
      s1.valid  <= 1'b0;
    end else begin
      s1.valid <= in_acc;
      if (in_acc) begin
        if (s_axis_tlast || last_col) begin
          col <= '0;
        end else begin
          col <= col + COL_W'(1);
        end
        if (s_axis_tlast) begin
          first_row <= 1'b1;
        end else if (last_col) begin
          first_row <= 1'b0;
        end
        s1.px        <= s_axis_tdata[0];
        s1.eof       <= s_axis_tlast;
        s1.first_col <= (col == '0);
        s1.last_col  <= last_col;
        s1.first_row <= first_row;
        s1_col       <= col;
        // same-cycle write from the item ahead bypasses the read
        fwd_vd       <= s1.valid && (s1_col == col);
        fwd_a        <= s1.valid && (s1_col == anti_raddr);
        fwd_v_val    <= v_run;
        fwd_d_val    <= d_run;
        fwd_a_val    <= a_run;
      end
    end
  end

  lol_ram #(
    .DEPTH (MAX_COLS),
    .WIDTH (2 * RUN_W),
    .AW    (COL_W)
  ) u_vd_ram (
    .clk   (clk),
    .we    (s1.valid),
    .waddr (s1_col),
    .wdata ({d_run, v_run}),
    .re    (in_acc),
    .raddr (col),
    .rdata (vd_rdata)
  );

  lol_ram #(
    .DEPTH (MAX_COLS),
    .WIDTH (RUN_W),
    .AW    (COL_W)
  ) u_anti_ram (
    .clk   (clk),
    .we    (s1.valid),
    .waddr (s1_col),
    .wdata (a_run),
    .re    (in_acc),
    .raddr (anti_raddr),
    .rdata (anti_rdata)
  );

  // back: run update and write-back
  always_comb begin
    up       = s1.first_row ? '0 : (fwd_vd ? fwd_v_val : vd_rdata[RUN_W-1:0]);
    old_diag = fwd_vd ? fwd_d_val : vd_rdata[2*RUN_W-1:RUN_W];
    up_right = (s1.first_row || s1.last_col) ? '0 : (fwd_a ? fwd_a_val : anti_rdata);
    up_left  = (s1.first_row || s1.first_col) ? '0 : upper_left_hold;
    if (s1.px) begin
      h_run = grow(s1.first_col ? '0 : horizontal_run);
      v_run = grow(up);
      d_run = grow(up_left);
      a_run = grow(up_right);
    end else begin
      h_run = '0;
      v_run = '0;
      d_run = '0;
      a_run = '0;
    end
    longest_next = wider(longest_so_far, wider(wider(h_run, v_run), wider(d_run, a_run)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      horizontal_run  <= '0;
      upper_left_hold <= '0;
      longest_so_far  <= '0;
    end else if (s1.valid) begin
      if (s1.eof) begin
        horizontal_run  <= '0;
        upper_left_hold <= '0;
        longest_so_far  <= '0;
      end else begin
        horizontal_run  <= h_run;
        upper_left_hold <= old_diag;
        longest_so_far  <= longest_next;
      end
    end
  end

  assign res_push = s1.valid && s1.eof;

  lol_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (RUN_OUT_W'(longest_next)),
    .pop       (m_axis_tready),
    .valid     (m_axis_tvalid),
    .data      (res_data),
    .count     (res_count)
  );

  assign m_axis_tdata = OUT_TDATA_W'(res_data);

endmodule

/* hdl/lol_checker.sv */
module lol_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tlast,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [lol_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  import lol_pkg::*;

  logic in_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // every accepted frame end is followed by a valid result on the output
  a_eof_result: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_axis_tlast |-> ##2 m_axis_tvalid)
    else $error("no result after end of frame");

  // a result only appears after an end-of-frame transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(in_acc && s_axis_tlast, 2))
    else $error("result without end of frame");

endmodule

bind longest_line_of_ones lol_checker u_lol_checker (.*);
